@@ sv/lsr_pkg.sv @@
// shared types, constants and helpers of the line segment rasterizer
package lsr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode opcode;
        t_coord  start_x;
        t_coord  start_y;
        t_coord  end_x;
        t_coord  end_y;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_pix;

    // one unit toward the end, wrapping at the coordinate width
    function automatic t_coord step_one(input t_coord v, input logic down);
        t_coord r;
        if (down) begin
            r = v - t_coord'(1);
        end else begin
            r = v + t_coord'(1);
        end
        return r;
    endfunction

endpackage

@@ sv/lsr_req_if.sv @@
// request channel carrying segment start and advance commands
interface lsr_req_if;
    logic          valid;
    logic          ready;
    lsr_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/lsr_pix_if.sv @@
// result channel carrying one pixel per request
interface lsr_pix_if;
    logic          valid;
    logic          ready;
    lsr_pkg::t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/lsr_core.sv @@
// segment state and combinational step logic of the rasterizer
module lsr_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  lsr_pkg::t_req i_req,
    output lsr_pkg::t_pix o_pix
);

    lsr_pkg::t_coord r_cur_x, n_cur_x;
    lsr_pkg::t_coord r_cur_y, n_cur_y;
    lsr_pkg::t_coord r_tgt_x, n_tgt_x;
    lsr_pkg::t_coord r_tgt_y, n_tgt_y;
    lsr_pkg::t_err   r_err, n_err;
    lsr_pkg::t_coord r_dmin, n_dmin;
    lsr_pkg::t_coord r_dmaj, n_dmaj;
    logic            r_ymaj, n_ymaj;
    logic            r_xdown, n_xdown;
    logic            r_ydown, n_ydown;
    logic            r_busy, n_busy;

    lsr_pkg::t_coord w_adx, w_ady;
    logic            w_xdown, w_ydown, w_ymaj;
    lsr_pkg::t_err   w_err_sum;
    logic            w_step_minor;
    logic            w_emit;
    logic            w_last;

    always_comb begin
        // start: direction and deltas of the new segment
        w_xdown = i_req.end_x < i_req.start_x;
        w_ydown = i_req.end_y < i_req.start_y;
        w_adx   = w_xdown ? (i_req.start_x - i_req.end_x) : (i_req.end_x - i_req.start_x);
        w_ady   = w_ydown ? (i_req.start_y - i_req.end_y) : (i_req.end_y - i_req.start_y);
        w_ymaj  = w_ady > w_adx;

        // advance: error update
        w_err_sum    = r_err + lsr_pkg::t_err'({1'b0, r_dmin});
        w_step_minor = !w_err_sum[lsr_pkg::ERR_BITS-1] && (w_err_sum != '0);

        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_tgt_x = r_tgt_x;
        n_tgt_y = r_tgt_y;
        n_err   = r_err;
        n_dmin  = r_dmin;
        n_dmaj  = r_dmaj;
        n_ymaj  = r_ymaj;
        n_xdown = r_xdown;
        n_ydown = r_ydown;
        w_emit  = 1'b0;

        if (i_req.opcode == lsr_pkg::OP_START) begin
            w_emit  = 1'b1;
            n_xdown = w_xdown;
            n_ydown = w_ydown;
            n_ymaj  = w_ymaj;
            n_dmaj  = w_ymaj ? w_ady : w_adx;
            n_dmin  = w_ymaj ? w_adx : w_ady;
            n_err   = '0;
            n_cur_x = i_req.start_x;
            n_cur_y = i_req.start_y;
            n_tgt_x = i_req.end_x;
            n_tgt_y = i_req.end_y;
        end else if (r_busy) begin
            w_emit = 1'b1;
            n_err  = w_step_minor ? (w_err_sum - lsr_pkg::t_err'({1'b0, r_dmaj})) : w_err_sum;
            if (r_ymaj) begin
                n_cur_y = lsr_pkg::step_one(r_cur_y, r_ydown);
                if (w_step_minor) begin
                    n_cur_x = lsr_pkg::step_one(r_cur_x, r_xdown);
                end
            end else begin
                n_cur_x = lsr_pkg::step_one(r_cur_x, r_xdown);
                if (w_step_minor) begin
                    n_cur_y = lsr_pkg::step_one(r_cur_y, r_ydown);
                end
            end
        end

        w_last = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
        n_busy = w_emit ? !w_last : r_busy;

        if (w_emit) begin
            o_pix.pixel_x     = n_cur_x;
            o_pix.pixel_y     = n_cur_y;
            o_pix.pixel_valid = 1'b1;
            o_pix.last_pixel  = w_last;
        end else begin
            o_pix.pixel_x     = '0;
            o_pix.pixel_y     = '0;
            o_pix.pixel_valid = 1'b0;
            o_pix.last_pixel  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_tgt_x <= '0;
            r_tgt_y <= '0;
            r_err   <= '0;
            r_dmin  <= '0;
            r_dmaj  <= '0;
            r_ymaj  <= 1'b0;
            r_xdown <= 1'b0;
            r_ydown <= 1'b0;
            r_busy  <= 1'b0;
        end else if (i_fire) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_tgt_x <= n_tgt_x;
            r_tgt_y <= n_tgt_y;
            r_err   <= n_err;
            r_dmin  <= n_dmin;
            r_dmaj  <= n_dmaj;
            r_ymaj  <= n_ymaj;
            r_xdown <= n_xdown;
            r_ydown <= n_ydown;
            r_busy  <= n_busy;
        end
    end

    // error term plus major delta, one bit wider, for the lower bound check
    logic signed [lsr_pkg::ERR_BITS:0] w_err_floor;
    assign w_err_floor = {r_err[lsr_pkg::ERR_BITS-1], r_err}
                       + $signed({2'b00, r_dmaj});

    a_err_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err[lsr_pkg::ERR_BITS-1] || (r_err == '0))
        else $error("error term went positive");

    a_err_above_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (w_err_floor > 0))
        else $error("error term at or below minus the major delta");

    a_minor_le_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dmin <= r_dmaj)
        else $error("minor delta exceeds major delta");

    a_zero_length_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_req.opcode == lsr_pkg::OP_START)
            && (i_req.start_x == i_req.end_x) && (i_req.start_y == i_req.end_y))
        |=> !r_busy)
        else $error("zero-length segment left the block busy");

endmodule

@@ sv/line_segment_rasterizer.sv @@
// top level of the line segment rasterizer with request and pixel registers
//
//   channel  dir  payload                                      handshake
//   i_req    in   opcode, start_x, start_y, end_x, end_y       valid/ready
//   o_pix    out  pixel_x, pixel_y, pixel_valid, last_pixel    valid/ready
//
// one pixel per clock sustained while the pixel sink is ready; each request passes through
// the request register and then the pixel register
// the step (error add, compare, coordinate increment) is the only logic between them
// reset clears the segment state to idle and empties both registers
// a stalled pixel register still lets one more request be taken
module line_segment_rasterizer (
    input logic   i_clk,
    input logic   i_rst_n,
    lsr_req_if.sink   i_req,
    lsr_pix_if.source o_pix
);

    logic          r_in_valid;
    lsr_pkg::t_req r_in;
    logic          r_out_valid;
    lsr_pkg::t_pix r_out;

    logic          w_out_free;
    logic          w_fire;
    lsr_pkg::t_pix w_pix;

    assign w_out_free  = !r_out_valid || o_pix.ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;

    assign o_pix.valid   = r_out_valid;
    assign o_pix.payload = r_out;

    lsr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_in),
        .o_pix   (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (w_fire) begin
            r_out <= w_pix;
        end
    end

endmodule

@@ tb/tb_line_segment_rasterizer.sv @@
// testbench of the line segment rasterizer: directed and random segments checked against a predictor
`timescale 1ns / 100ps

module tb_line_segment_rasterizer;

    import lsr_pkg::*;

    localparam int HOLD_CYCLES = 48;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsr_req_if req_ch ();
    lsr_pix_if pix_ch ();

    line_segment_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_pix   (pix_ch)
    );

    always #1 i_clk = ~i_clk;

    t_pix pixel_expect[$];
    int   fail_count = 0;
    int   reqs_sent  = 0;
    bit   no_idle    = 1'b0;
    bit   sink_hold  = 1'b0;

    // predictor state, zero after reset
    t_coord ras_x       = '0;
    t_coord ras_y       = '0;
    t_coord ras_end_x   = '0;
    t_coord ras_end_y   = '0;
    int     ras_err     = 0;
    t_coord ras_d_minor = '0;
    t_coord ras_d_major = '0;
    logic   ras_y_major = 1'b0;
    logic   ras_x_down  = 1'b0;
    logic   ras_y_down  = 1'b0;
    logic   ras_active  = 1'b0;

    task automatic predict_pixel(input t_req r, output t_pix p);
        t_coord adx;
        t_coord ady;
        logic   hit;
        p = '0;
        if (r.opcode == OP_START) begin
            ras_x_down  = r.end_x < r.start_x;
            ras_y_down  = r.end_y < r.start_y;
            adx         = ras_x_down ? r.start_x - r.end_x : r.end_x - r.start_x;
            ady         = ras_y_down ? r.start_y - r.end_y : r.end_y - r.start_y;
            ras_y_major = ady > adx;
            ras_d_major = ras_y_major ? ady : adx;
            ras_d_minor = ras_y_major ? adx : ady;
            ras_err     = 0;
            ras_x       = r.start_x;
            ras_y       = r.start_y;
            ras_end_x   = r.end_x;
            ras_end_y   = r.end_y;
        end else if (ras_active) begin
            ras_err += int'(ras_d_minor);
            if (ras_err > 0) begin
                ras_err -= int'(ras_d_major);
                if (ras_y_major) begin
                    ras_x = ras_x_down ? ras_x - 1'b1 : ras_x + 1'b1;
                end else begin
                    ras_y = ras_y_down ? ras_y - 1'b1 : ras_y + 1'b1;
                end
            end
            if (ras_y_major) begin
                ras_y = ras_y_down ? ras_y - 1'b1 : ras_y + 1'b1;
            end else begin
                ras_x = ras_x_down ? ras_x - 1'b1 : ras_x + 1'b1;
            end
        end else begin
            return;
        end
        hit           = (ras_x == ras_end_x) && (ras_y == ras_end_y);
        ras_active    = !hit;
        p.pixel_x     = ras_x;
        p.pixel_y     = ras_y;
        p.pixel_valid = 1'b1;
        p.last_pixel  = hit;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : pixel_check
        t_pix got;
        t_pix want;
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                got = pix_ch.payload;
                if (pixel_expect.size() == 0) begin
                    $error("pixel with no request pending: x %0d y %0d",
                           got.pixel_x, got.pixel_y);
                    fail_count++;
                end else begin
                    want = pixel_expect.pop_front();
                    check_field("pixel_x", want.pixel_x, got.pixel_x);
                    check_field("pixel_y", want.pixel_y, got.pixel_y);
                    check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
                    check_field("last_pixel", want.last_pixel, got.last_pixel);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                predict_pixel(req_ch.payload, want);
                pixel_expect.push_back(want);
            end
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    initial begin : pixel_sink
        int gap;
        gap = 0;
        pix_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                sink_hold = 1'b0;
            end else if (gap > 0) begin
                pix_ch.ready <= 1'b0;
                gap--;
            end else begin
                pix_ch.ready <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    task automatic send_req(input t_req r);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        reqs_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pixel_expect.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req noise_req(input t_opcode op);
        t_req r;
        r.opcode  = op;
        r.start_x = t_coord'($urandom);
        r.start_y = t_coord'($urandom);
        r.end_x   = t_coord'($urandom);
        r.end_y   = t_coord'($urandom);
        return r;
    endfunction

    task automatic send_start(input t_coord x1, y1, x2, y2);
        t_req r;
        r = noise_req(OP_START);
        r.start_x = x1;
        r.start_y = y1;
        r.end_x   = x2;
        r.end_y   = y2;
        send_req(r);
    endtask

    task automatic send_advances(input int n);
        repeat (n) send_req(noise_req(OP_ADVANCE));
    endtask

    function automatic int major_span(input t_coord x1, y1, x2, y2);
        int adx;
        int ady;
        adx = (x2 > x1) ? x2 - x1 : x1 - x2;
        ady = (y2 > y1) ? y2 - y1 : y1 - y2;
        return (adx > ady) ? adx : ady;
    endfunction

    task automatic draw_line(input t_coord x1, y1, x2, y2);
        send_start(x1, y1, x2, y2);
        send_advances(major_span(x1, y1, x2, y2));
    endtask

    function automatic t_coord pick_coord();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? t_coord'(COORD_MAX) : t_coord'(0);
        end
        return t_coord'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic int pick_span();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(0, 12);
        end
        return $urandom_range(13, 80);
    endfunction

    // keeps the other endpoint inside the coordinate range
    function automatic t_coord offset_coord(input t_coord c, input int span);
        if ($urandom_range(0, 1) && int'(c) >= span) begin
            return t_coord'(int'(c) - span);
        end else if (int'(c) + span <= COORD_MAX) begin
            return t_coord'(int'(c) + span);
        end
        return t_coord'(int'(c) - span);
    endfunction

    task automatic test_idle_advance();
        send_advances(1);
    endtask

    task automatic test_directed_lines();
        send_start(5, 5, 5, 5);
        send_advances(1);
        draw_line(0, COORD_MAX, 2, COORD_MAX);
        draw_line(COORD_MAX, 3, COORD_MAX, 0);
        draw_line(10, 10, 7, 13);
        draw_line(100, 200, 102, 195);
    endtask

    task automatic test_restart_while_busy();
        send_start(0, 0, COORD_MAX, COORD_MAX);
        send_advances(1);
        send_start(COORD_MAX, 0, 0, COORD_MAX);
        send_advances(1);
        send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    endtask

    task automatic test_random_segments(input int n_reqs);
        int     stop_at;
        int     kind;
        int     dx;
        int     dy;
        int     full;
        int     adv;
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        stop_at = reqs_sent + n_reqs;
        while (reqs_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                send_req(noise_req(t_opcode'($urandom_range(0, 1))));
            end else if (kind < 12) begin
                send_start(t_coord'($urandom), t_coord'($urandom),
                           t_coord'($urandom), t_coord'($urandom));
                send_advances($urandom_range(0, 8));
            end else begin
                dx = pick_span();
                dy = ($urandom_range(0, 6) == 0) ? dx : pick_span();
                x1 = pick_coord();
                y1 = pick_coord();
                x2 = offset_coord(x1, dx);
                y2 = offset_coord(y1, dy);
                full = major_span(x1, y1, x2, y2);
                adv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, full) : full;
                send_start(x1, y1, x2, y2);
                send_advances(adv);
                if ($urandom_range(0, 9) == 0) begin
                    send_advances($urandom_range(1, 2));
                end
            end
        end
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        test_random_segments(120);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        no_idle   = 1'b1;
        sink_hold = 1'b1;
        draw_line(300, 40, 310, 44);
        no_idle = 1'b0;
        wait_for_drain();
        draw_line(4000, COORD_MAX - 5, 3991, COORD_MAX);
        wait_for_drain();
    endtask

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_advance();
        test_directed_lines();
        test_restart_while_busy();
        test_random_segments(1000);
        test_streaming();
        test_backpressure();

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_line_segment_rasterizer: clean");
        end else begin
            $display("tb_line_segment_rasterizer: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_line_segment_rasterizer: errors");
        $finish;
    end

endmodule
